FILE: design/pipc_pkg.sv
package pipc_pkg;

    localparam int COORD_W = 32;   // coordinate port width
    localparam int INDEX_W = 8;    // vertex slot field width
    localparam int COUNT_W = 9;    // vertex_count register width

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic                      is_query;
        logic                      wr_in_range;  // write slot exists in the table
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] x;            // already sign-extended from COORD_BITS
        logic signed [COORD_W-1:0] y;
    } pipc_cmd_t;

endpackage

FILE: design/pipc_front.sv
module pipc_front #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 32
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [pipc_pkg::INDEX_W-1:0]      s_index,
    input  logic signed [pipc_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [pipc_pkg::COORD_W-1:0] s_coord_y,
    input  logic                              q_full,
    output logic                              q_push,
    output pipc_pkg::pipc_cmd_t               q_cmd
);
    import pipc_pkg::*;

    localparam int SH = COORD_W - COORD_BITS;

    logic signed [COORD_W-1:0] x_sh;
    logic signed [COORD_W-1:0] y_sh;
    logic [31:0]               idx_ext;

    always_comb begin
        // keep low COORD_BITS, sign-extend to port width
        x_sh    = s_coord_x <<< SH;
        y_sh    = s_coord_y <<< SH;
        idx_ext = {{(32-INDEX_W){1'b0}}, s_index};

        q_cmd.is_query    = (s_action == ACT_QUERY);
        q_cmd.wr_in_range = (idx_ext < 32'(MAX_VERTICES));
        q_cmd.index       = s_index;
        q_cmd.x           = x_sh >>> SH;
        q_cmd.y           = y_sh >>> SH;

        s_ready = !q_full;
        q_push  = s_valid && !q_full;
    end

endmodule

FILE: design/pipc_queue.sv
module pipc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pipc_pkg::pipc_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output pipc_pkg::pipc_cmd_t pop_cmd
);
    import pipc_pkg::*;

    // two-entry FIFO
    pipc_cmd_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    logic do_push;
    logic do_pop;

    always_comb begin
        full      = (cnt_reg == 2'd2);
        pop_valid = (cnt_reg != 2'd0);
        pop_cmd   = slot_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && pop_valid;
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: design/pipc_back.sv
module pipc_back #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pipc_pkg::COUNT_W-1:0] vertex_count,
    input  logic                         q_valid,
    input  pipc_pkg::pipc_cmd_t          q_cmd,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_answer,
    output logic                         m_inside_res
);
    import pipc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int DW     = CB + 1;          // difference width
    localparam int PW     = 2 * DW;          // product width
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} state_t;

    state_t state_reg;

    // vertex table: {x, y}
    logic [2*CB-1:0] vtx_mem [MAX_VERTICES];
    logic [2*CB-1:0] rd_data_reg;
    logic [2*CB-1:0] prev_reg;

    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] last_idx_reg;
    logic             rd_vld_reg;
    logic             rd_first_reg;
    logic             d_vld_reg;
    logic             p_vld_reg;
    logic             parity_reg;
    logic             res_answer_reg;
    logic             res_inside_reg;
    logic             m_valid_reg;
    logic             m_is_answer_reg;
    logic             m_inside_res_reg;

    logic signed [CB-1:0] px_reg;
    logic signed [CB-1:0] py_reg;

    // stage 1 results
    logic signed [DW-1:0] dxp_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] dyp_reg;
    logic signed [DW-1:0] dx_reg;
    logic                 qual_reg;
    logic                 up_reg;
    // stage 2 results
    logic signed [PW-1:0] a_reg;
    logic signed [PW-1:0] b_reg;
    logic                 up2_reg;

    logic [31:0]          cnt_ext;
    logic [31:0]          n_eff;
    logic [31:0]          last_ext;
    logic [31:0]          waddr_ext;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic                 out_free;
    logic                 walk_last;
    logic                 pipe_busy;
    logic                 hit;
    logic signed [CB-1:0] xi;
    logic signed [CB-1:0] yi;
    logic signed [CB-1:0] xj;
    logic signed [CB-1:0] yj;
    logic signed [DW-1:0] dxp;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dyp;
    logic signed [DW-1:0] dx;
    logic                 qual;
    logic                 up;

    always_comb begin
        q_pop    = (state_reg == ST_IDLE) && q_valid;
        cnt_ext  = {{(32-COUNT_W){1'b0}}, vertex_count};
        n_eff    = (cnt_ext > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : cnt_ext;
        last_ext = n_eff - 32'd1;
        out_free = !m_valid_reg || m_ready;

        waddr_ext = {{(32-INDEX_W){1'b0}}, q_cmd.index};
        mem_waddr = waddr_ext[ADDR_W-1:0];
        mem_we    = q_pop && !q_cmd.is_query && q_cmd.wr_in_range;

        walk_last = (rd_idx_reg == last_idx_reg);
        pipe_busy = rd_vld_reg || d_vld_reg || p_vld_reg;

        // edge from previous vertex (i) to just-read vertex (j)
        xi = $signed(prev_reg[2*CB-1:CB]);
        yi = $signed(prev_reg[CB-1:0]);
        xj = $signed(rd_data_reg[2*CB-1:CB]);
        yj = $signed(rd_data_reg[CB-1:0]);

        dxp  = {px_reg[CB-1], px_reg} - {xi[CB-1], xi};
        dyp  = {py_reg[CB-1], py_reg} - {yi[CB-1], yi};
        dy   = {yj[CB-1], yj} - {yi[CB-1], yi};
        dx   = {xj[CB-1], xj} - {xi[CB-1], xi};
        up   = (yi <= py_reg) && (yj > py_reg);
        qual = up || ((yi > py_reg) && (yj <= py_reg));

        // upward edge: (px-xi)*dy < (py-yi)*dx; downward: reversed
        hit = up2_reg ? (a_reg < b_reg) : (a_reg > b_reg);
    end

    // datapath: table, query point, arithmetic stages
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vtx_mem[mem_waddr] <= {q_cmd.x[CB-1:0], q_cmd.y[CB-1:0]};
        end
        rd_data_reg  <= vtx_mem[rd_idx_reg[ADDR_W-1:0]];
        rd_first_reg <= (rd_idx_reg == '0);
        if (rd_vld_reg) begin
            prev_reg <= rd_data_reg;
        end
        if (q_pop && q_cmd.is_query) begin
            px_reg <= q_cmd.x[CB-1:0];
            py_reg <= q_cmd.y[CB-1:0];
        end
        dxp_reg  <= dxp;
        dyp_reg  <= dyp;
        dy_reg   <= dy;
        dx_reg   <= dx;
        qual_reg <= qual;
        up_reg   <= up;
        a_reg    <= PW'(dxp_reg) * PW'(dy_reg);
        b_reg    <= PW'(dyp_reg) * PW'(dx_reg);
        up2_reg  <= up_reg;
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            rd_idx_reg       <= '0;
            last_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            d_vld_reg        <= 1'b0;
            p_vld_reg        <= 1'b0;
            parity_reg       <= 1'b0;
            res_answer_reg   <= 1'b0;
            res_inside_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_is_answer_reg  <= 1'b0;
            m_inside_res_reg <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == ST_WALK);
            d_vld_reg  <= rd_vld_reg && !rd_first_reg;
            p_vld_reg  <= d_vld_reg && qual_reg;
            if (p_vld_reg && hit) begin
                parity_reg <= !parity_reg;
            end
            // in ST_DONE the result register is reloaded below instead
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (!q_cmd.is_query) begin
                            res_answer_reg <= 1'b0;
                            res_inside_reg <= 1'b0;
                            state_reg      <= ST_DONE;
                        end else if (n_eff >= 32'd2) begin
                            parity_reg   <= 1'b0;
                            rd_idx_reg   <= '0;
                            last_idx_reg <= last_ext[CNT_W-1:0];
                            state_reg    <= ST_WALK;
                        end else begin
                            res_answer_reg <= 1'b1;
                            res_inside_reg <= 1'b0;
                            state_reg      <= ST_DONE;
                        end
                    end
                end
                ST_WALK: begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    if (walk_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        res_answer_reg <= 1'b1;
                        res_inside_reg <= parity_reg;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_is_answer_reg  <= res_answer_reg;
                        m_inside_res_reg <= res_inside_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_answer  = m_is_answer_reg;
    assign m_inside_res = m_inside_res_reg;

endmodule

FILE: design/point_in_polygon_crossing.sv
// Crossing-number point-in-polygon test on a stored closed polygon. Items on the
// s_ channel either write one vertex (action 0: coord_x/coord_y into slot index,
// slots at or above MAX_VERTICES are dropped) or query a point (action 1). Every
// item yields exactly one result on the m_ channel: is_answer 0 with inside_res 0
// acknowledges a write, is_answer 1 carries the query's inside/outside parity.
// Coordinates are signed Q16.16; only the low COORD_BITS bits are used, sign-
// extended. vertex_count (cfg port, 9 bits, reset 0, clamped to MAX_VERTICES)
// counts the stored vertices including the closing copy of the first, so edges
// run from slot i to i+1 for i below vertex_count-1; below two vertices a query
// answers outside. Write vertex_count only while no item is in flight. A query
// walks the vertex table through its single read port, which yields one vertex
// per cycle to the edge pipeline (difference, multiply, compare). Slots a query
// reads must have been written first; the table is not cleared at reset.
module point_in_polygon_crossing #(
    parameter int MAX_VERTICES = 256,   // 4 .. 4096
    parameter int COORD_BITS   = 32     // 8 .. 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: vertex_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pipc_pkg::COUNT_W-1:0]        cfg_data,
    // item input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [pipc_pkg::INDEX_W-1:0]        s_index,
    input  logic signed [pipc_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [pipc_pkg::COORD_W-1:0] s_coord_y,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_answer,
    output logic                                m_inside_res
);
    import pipc_pkg::*;

    logic [COUNT_W-1:0] vertex_count_reg;

    logic      q_full;
    logic      q_push;
    pipc_cmd_t push_cmd;
    logic      q_pop;
    logic      q_valid;
    pipc_cmd_t pop_cmd;

    // config register always accepts a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else if (cfg_valid) begin
            vertex_count_reg <= cfg_data;
        end
    end

    // front: accept and classify each item
    pipc_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_index   (s_index),
        .s_coord_x (s_coord_x),
        .s_coord_y (s_coord_y),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // two-item queue decouples intake from the edge walk
    pipc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // back: vertex table, edge walk, result register
    pipc_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .vertex_count (vertex_count_reg),
        .q_valid      (q_valid),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_answer  (m_is_answer),
        .m_inside_res (m_inside_res)
    );

endmodule
